>>> rtl/grdith_pkg.sv
package grdith_pkg;

  // Field widths
  localparam int unsigned DATA_W = 16;
  localparam int unsigned TIDX_W = 6;

  // Item kinds
  localparam logic OP_PIXEL       = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  // Luma weights 0.21 / 0.72 / 0.07 as ceil(w * 2^LUMA_FRAC); the rounding
  // error stays below 1/100 over the whole channel range, so the top bits
  // of the product equal floor(w * channel) exactly.
  localparam int unsigned LUMA_FRAC = 24;
  localparam logic [LUMA_FRAC-1:0] LUMA_K_R = 24'd3523216;
  localparam logic [LUMA_FRAC-1:0] LUMA_K_G = 24'd12079596;
  localparam logic [LUMA_FRAC-1:0] LUMA_K_B = 24'd1174406;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

>>> rtl/grdith_in_if.sv
interface grdith_in_if;
  import grdith_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [DATA_W-1:0] red;
  logic [DATA_W-1:0] green;
  logic [DATA_W-1:0] blue;
  logic              start_of_frame;
  logic [TIDX_W-1:0] table_index;
  logic [DATA_W-1:0] table_value;

  modport source (
    output valid, operation, red, green, blue, start_of_frame, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, operation, red, green, blue, start_of_frame, table_index, table_value,
    output ready
  );
endinterface

>>> rtl/grdith_out_if.sv
interface grdith_out_if;
  import grdith_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] grey;

  modport source (output valid, grey, input ready);
  modport sink (input valid, grey, output ready);
endinterface

>>> rtl/grdith_cfg_if.sv
interface grdith_cfg_if;
  import grdith_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] image_width;

  modport source (output valid, image_width, input ready);
  modport sink (input valid, image_width, output ready);
endinterface

>>> rtl/grdith_ram.sv
module grdith_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

>>> rtl/grdith_fifo.sv
module grdith_fifo #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != (PW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

>>> rtl/grdith_front.sv
module grdith_front #(
  parameter int unsigned ORDER_LOG2 = 3
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  grdith_in_if.sink                                in_px,
  input  logic [grdith_pkg::DATA_W-1:0]            image_width,
  output logic                                     q_valid,
  input  logic                                     q_ready,
  output logic [2*ORDER_LOG2+grdith_pkg::DATA_W:0] q_data
);
  import grdith_pkg::*;

  localparam int unsigned AW = 2 * ORDER_LOG2;
  localparam int unsigned PW = DATA_W + LUMA_FRAC;

  logic                  accept, is_pixel;
  logic [DATA_W-1:0]     col_r, col_nxt, col_base;
  logic [ORDER_LOG2-1:0] row_r, row_nxt, row_base;
  logic [DATA_W:0]       limit, col_inc;
  logic [AW-1:0]         item_addr;
  logic [PW-1:0]         prod_r, prod_g, prod_b;

  logic                  f1_v_r, f1_v_nxt;
  logic                  f1_op_r;
  logic [AW-1:0]         f1_addr_r;
  logic [DATA_W-1:0]     f1_tval_r;
  logic [DATA_W-1:0]     f1_lr_r, f1_lg_r, f1_lb_r;
  logic [DATA_W-1:0]     lum;
  logic [3:0]            nib;
  logic [DATA_W-1:0]     grey;

  assign in_px.ready = !f1_v_r || q_ready;
  assign accept      = in_px.valid && in_px.ready;
  assign is_pixel    = (in_px.operation == OP_PIXEL);

  // Raster position; start of frame restarts it before the pixel is used
  assign col_base = in_px.start_of_frame ? '0 : col_r;
  assign row_base = in_px.start_of_frame ? '0 : row_r;
  assign limit    = (image_width == '0) ? {1'b1, {DATA_W{1'b0}}} : {1'b0, image_width};
  assign col_inc  = {1'b0, col_base} + (DATA_W+1)'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && is_pixel) begin
      if (col_inc >= limit) begin
        col_nxt = '0;
        row_nxt = row_base + ORDER_LOG2'(1);
      end else begin
        col_nxt = col_inc[DATA_W-1:0];
        row_nxt = row_base;
      end
    end
  end

  // Table address: threshold cell for a pixel, target entry for a write
  assign item_addr = is_pixel ? {row_base, col_base[ORDER_LOG2-1:0]}
                              : AW'(in_px.table_index);

  // Weighted channels, one multiplier per channel
  assign prod_r = in_px.red * LUMA_K_R;
  assign prod_g = in_px.green * LUMA_K_G;
  assign prod_b = in_px.blue * LUMA_K_B;

  assign f1_v_nxt = in_px.ready ? accept : f1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      f1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r   <= in_px.operation;
      f1_addr_r <= item_addr;
      f1_tval_r <= in_px.table_value;
      f1_lr_r   <= prod_r[PW-1:LUMA_FRAC];
      f1_lg_r   <= prod_g[PW-1:LUMA_FRAC];
      f1_lb_r   <= prod_b[PW-1:LUMA_FRAC];
    end
  end

  // Luma sum and quantised grey: top three bits, low bit of nibble cleared
  assign lum  = f1_lr_r + f1_lg_r + f1_lb_r;
  assign nib  = {lum[DATA_W-1 -: 3], 1'b0};
  assign grey = {nib, nib, nib, nib};

  assign q_valid = f1_v_r;
  assign q_data  = {f1_op_r, f1_addr_r, (f1_op_r == OP_TABLE_WRITE) ? f1_tval_r : grey};
endmodule

>>> rtl/grdith_back.sv
module grdith_back #(
  parameter int unsigned ORDER_LOG2 = 3
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  output logic                                     q_ready,
  input  logic [2*ORDER_LOG2+grdith_pkg::DATA_W:0] q_data,
  grdith_out_if.source                             out_px
);
  import grdith_pkg::*;

  localparam int unsigned AW = 2 * ORDER_LOG2;

  logic              q_op;
  logic [AW-1:0]     q_addr;
  logic [DATA_W-1:0] q_val;
  logic              pop, rd_en, wr_en;
  logic              out_free, out_load, b1_free;
  logic [DATA_W-1:0] thresh;

  logic              b1_v_r, b1_v_nxt;
  logic [DATA_W-1:0] b1_grey_r;
  logic              out_v_r, out_v_nxt;
  logic [DATA_W-1:0] out_grey_r;

  // Queue head
  assign q_op   = q_data[DATA_W+AW];
  assign q_addr = q_data[DATA_W +: AW];
  assign q_val  = q_data[DATA_W-1:0];

  // Stage flow: output register, then lookup stage, then queue pop
  assign out_free = !out_v_r || out_px.ready;
  assign out_load = b1_v_r && out_free;
  assign b1_free  = !b1_v_r || out_load;
  assign q_ready  = b1_free;
  assign pop      = q_valid && b1_free;
  assign rd_en    = pop && (q_op == OP_PIXEL);
  assign wr_en    = pop && (q_op == OP_TABLE_WRITE);

  grdith_ram #(
    .WIDTH (DATA_W),
    .DEPTH (1 << AW)
  ) u_thresh (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_addr),
    .wr_data (q_val),
    .rd_en   (rd_en),
    .rd_addr (q_addr),
    .rd_data (thresh)
  );

  assign b1_v_nxt  = b1_free ? rd_en : b1_v_r;
  assign out_v_nxt = out_free ? b1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Grey passes only if strictly above its threshold
  always_ff @(posedge clk) begin
    if (rd_en) begin
      b1_grey_r <= q_val;
    end
    if (out_load) begin
      out_grey_r <= (b1_grey_r > thresh) ? b1_grey_r : '0;
    end
  end

  assign out_px.valid = out_v_r;
  assign out_px.grey  = out_grey_r;
endmodule

>>> rtl/grey_ordered_dither_top.sv
// Result path: front register, queue, lookup stage, output register; stalls hold a beat.
// Throughput: one item per clock while out_px.ready allows; the per-channel luma multipliers,
// the queue and the threshold RAM (one write port, one read port) each take one item a cycle.
// Reset (synchronous, rst_n low): pipeline and queue emptied, raster position cleared,
// image width set to 1. The threshold table is not cleared and holds garbage until written.
module grey_ordered_dither_top #(
  parameter int unsigned MATRIX_ORDER_LOG2 = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  grdith_in_if.sink    in_px,
  grdith_out_if.source out_px,
  grdith_cfg_if.sink   cfg_wr
);
  import grdith_pkg::*;

  localparam int unsigned EW = 2 * MATRIX_ORDER_LOG2 + DATA_W + 1;

  logic [DATA_W-1:0] image_width_r, image_width_nxt;
  logic              fe_valid, fe_ready;
  logic [EW-1:0]     fe_data;
  logic              be_valid, be_ready;
  logic [EW-1:0]     be_data;

  // Width register, always writable
  assign cfg_wr.ready    = 1'b1;
  assign image_width_nxt = cfg_wr.valid ? cfg_wr.image_width : image_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= DATA_W'(1);
    end else begin
      image_width_r <= image_width_nxt;
    end
  end

  grdith_front #(
    .ORDER_LOG2 (MATRIX_ORDER_LOG2)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_px       (in_px),
    .image_width (image_width_r),
    .q_valid     (fe_valid),
    .q_ready     (fe_ready),
    .q_data      (fe_data)
  );

  grdith_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_data),
    .pop_valid  (be_valid),
    .pop_ready  (be_ready),
    .pop_data   (be_data)
  );

  grdith_back #(
    .ORDER_LOG2 (MATRIX_ORDER_LOG2)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (be_valid),
    .q_ready (be_ready),
    .q_data  (be_data),
    .out_px  (out_px)
  );

`ifndef SYNTH
  // A passing grey is one nibble, low bit clear, in all four places
  a_grey_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid |-> (out_px.grey[12] == 1'b0) &&
                     (out_px.grey[15:12] == out_px.grey[11:8]) &&
                     (out_px.grey[11:8] == out_px.grey[7:4]) &&
                     (out_px.grey[7:4] == out_px.grey[3:0]))
    else $error("grey result not a replicated quantised nibble");

  // Reset leaves nothing in flight
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_px.valid && !fe_valid && !be_valid)
    else $error("pipeline not empty after reset");
`endif
endmodule
